// File: hw/rtl/oar_pkg.sv
// oar_pkg: shared types, codes and memory map constants for the operand
// address resolver. No dependencies; imported by every module of the block.

package oar_pkg;

  // internal ram size; a power of two between 256 and 8192 bytes
  localparam int unsigned RAM_DEPTH = 2048;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  // memory map
  localparam logic [15:0] RAM_TOP   = 16'h1FFF;
  localparam logic [15:0] VID_BASE  = 16'h2000;
  localparam logic [15:0] VID_TOP   = 16'h3FFF;
  localparam logic [15:0] DMA_ADDR  = 16'h4014;
  localparam logic [15:0] CTRL_ADDR = 16'h4016;

  // access command
  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // addressing mode codes; the unused codes behave as immediate
  typedef enum logic [2:0] {
    MODE_IMM   = 3'd0,
    MODE_ZP    = 3'd1,
    MODE_ABS   = 3'd2,
    MODE_IND_X = 3'd3,
    MODE_IND_Y = 3'd4
  } mode_t;

  // result target codes
  typedef enum logic [2:0] {
    TGT_RAM   = 3'd0,
    TGT_VIDEO = 3'd1,
    TGT_DMA   = 3'd2,
    TGT_CTRL  = 3'd3,
    TGT_EXT   = 3'd4,
    TGT_IMM   = 3'd5
  } target_t;

  // class of an incoming mode, as the controller sees it
  typedef enum logic [1:0] {
    KIND_IMM,
    KIND_DIRECT,
    KIND_INDIRECT
  } kind_t;

  // ram address source
  typedef enum logic [1:0] {
    RAS_PTR_LO,
    RAS_PTR_HI,
    RAS_EA
  } ras_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_LO,
    ST_PTR_HI,
    ST_PTR_ADD,
    ST_ACCESS,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new word and form direct address
    ras_t ram_sel;   // ram address source
    logic ram_rd;    // ram read this cycle
    logic access;    // data access cycle
    logic ptr_cap;   // capture pointer low byte
    logic ptr_form;  // form address from pointer
  } oar_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t in_kind;  // class of the mode on the input ports
  } oar_stat_t;

endpackage

// File: hw/rtl/oar_ctrl.sv
// oar_ctrl: sequencer for the operand address resolver.
// Depends on oar_pkg; drives the datapath oar_dp through oar_cmd_t.

module oar_ctrl
  import oar_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  oar_stat_t stat,
  output oar_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.ram_sel  = RAS_EA;
    cmd.ram_rd   = 1'b0;
    cmd.access   = 1'b0;
    cmd.ptr_cap  = 1'b0;
    cmd.ptr_form = 1'b0;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (stat.in_kind)
            KIND_INDIRECT: state_next = ST_PTR_LO;
            KIND_DIRECT:   state_next = ST_ACCESS;
            default:       state_next = ST_DONE;
          endcase
        end
      end
      ST_PTR_LO: begin
        cmd.ram_sel = RAS_PTR_LO;
        cmd.ram_rd  = 1'b1;
        state_next  = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        cmd.ram_sel = RAS_PTR_HI;
        cmd.ram_rd  = 1'b1;
        cmd.ptr_cap = 1'b1;
        state_next  = ST_PTR_ADD;
      end
      ST_PTR_ADD: begin
        cmd.ptr_form = 1'b1;
        state_next   = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.ram_sel = RAS_EA;
        cmd.ram_rd  = 1'b1;
        cmd.access  = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/oar_dp.sv
// oar_dp: datapath of the operand address resolver: word registers,
// address forming, internal ram and memory map decode. Depends on oar_pkg.

module oar_dp
  import oar_pkg::*;
(
  input  logic        clk,
  input  oar_cmd_t    cmd,
  output oar_stat_t   stat,
  input  logic        command,
  input  logic [2:0]  mode,
  input  logic [15:0] operand,
  input  logic [7:0]  index_value,
  input  logic [7:0]  write_data,
  output logic [2:0]  target,
  output logic [15:0] effective_address,
  output logic [2:0]  port_select,
  output logic [7:0]  read_data,
  output logic [7:0]  forward_data,
  output logic        error
);

  logic [7:0]        mem [RAM_DEPTH];

  logic              cmd_q;
  logic [2:0]        mode_q;
  logic [15:0]       opnd_q;
  logic [7:0]        idx_q;
  logic [7:0]        wdata_q;
  logic [15:0]       addr_q;
  logic [7:0]        ptr_lo_q;
  logic [7:0]        rdata_q;

  logic [15:0]       direct_addr;
  logic [7:0]        ptr_base;
  logic [7:0]        ptr_next;
  logic [15:0]       ptr_full;
  logic [RAM_AW-1:0] ram_addr;
  logic              ram_we;
  logic              is_imm_q;
  logic              is_wr;
  target_t           tgt;

  // classify the incoming mode
  always_comb begin
    case (mode_t'(mode))
      MODE_ZP, MODE_ABS:      stat.in_kind = KIND_DIRECT;
      MODE_IND_X, MODE_IND_Y: stat.in_kind = KIND_INDIRECT;
      default:                stat.in_kind = KIND_IMM;
    endcase
  end

  // direct address from the ports: zero page wraps in 8 bits
  always_comb begin
    if (mode_t'(mode) == MODE_ZP) begin
      direct_addr = {8'h00, operand[7:0] + index_value};
    end else begin
      direct_addr = operand + {8'h00, index_value};
    end
  end

  // zero page pointer location, second byte wraps in zero page
  assign ptr_base = (mode_t'(mode_q) == MODE_IND_X) ? opnd_q[7:0] + idx_q : opnd_q[7:0];
  assign ptr_next = ptr_base + 8'd1;
  assign ptr_full = {rdata_q, ptr_lo_q};

  // word and address registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= command;
      mode_q  <= mode;
      opnd_q  <= operand;
      idx_q   <= index_value;
      wdata_q <= write_data;
      addr_q  <= direct_addr;
    end else if (cmd.ptr_form) begin
      if (mode_t'(mode_q) == MODE_IND_Y) begin
        addr_q <= ptr_full + {8'h00, idx_q};
      end else begin
        addr_q <= ptr_full;
      end
    end
    if (cmd.ptr_cap) begin
      ptr_lo_q <= rdata_q;
    end
  end

  // ram address select
  always_comb begin
    case (cmd.ram_sel)
      RAS_PTR_LO: ram_addr = RAM_AW'(ptr_base);
      RAS_PTR_HI: ram_addr = RAM_AW'(ptr_next);
      default:    ram_addr = addr_q[RAM_AW-1:0];
    endcase
  end

  assign is_wr  = (cmd_t'(cmd_q) == CMD_WRITE);
  assign ram_we = cmd.access && is_wr && (tgt == TGT_RAM);

  // internal ram, one port, registered read
  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_addr] <= wdata_q;
    end else if (cmd.ram_rd) begin
      rdata_q <= mem[ram_addr];
    end
  end

  // memory map decode
  always_comb begin
    case (mode_t'(mode_q))
      MODE_ZP, MODE_ABS, MODE_IND_X, MODE_IND_Y: is_imm_q = 1'b0;
      default:                                   is_imm_q = 1'b1;
    endcase
  end

  always_comb begin
    if (is_imm_q) begin
      tgt = TGT_IMM;
    end else if (addr_q <= RAM_TOP) begin
      tgt = TGT_RAM;
    end else if (addr_q <= VID_TOP) begin
      tgt = TGT_VIDEO;
    end else if (addr_q == DMA_ADDR) begin
      tgt = TGT_DMA;
    end else if (addr_q[15:1] == CTRL_ADDR[15:1]) begin
      tgt = TGT_CTRL;
    end else begin
      tgt = TGT_EXT;
    end
  end

  // result fields
  always_comb begin
    effective_address = addr_q;
    port_select       = 3'd0;
    read_data         = 8'h00;
    forward_data      = 8'h00;
    error             = 1'b0;
    case (tgt)
      TGT_IMM: begin
        effective_address = 16'h0000;
        if (is_wr) begin
          error = 1'b1;
        end else begin
          read_data = opnd_q[7:0];
        end
      end
      TGT_RAM: begin
        effective_address = {{(16 - RAM_AW){1'b0}}, addr_q[RAM_AW-1:0]};
        if (!is_wr) begin
          read_data = rdata_q;
        end
      end
      TGT_VIDEO: begin
        port_select       = addr_q[2:0];
        effective_address = VID_BASE | {13'h0000, addr_q[2:0]};
        if (is_wr) begin
          forward_data = wdata_q;
        end
      end
      TGT_CTRL: begin
        port_select = {2'b00, addr_q[0]};
        if (is_wr) begin
          forward_data = {7'h00, wdata_q[0]};
        end
      end
      default: begin
        if (is_wr) begin
          forward_data = wdata_q;
        end
      end
    endcase
  end

  assign target = tgt;

endmodule

// File: hw/rtl/cpu_operand_address_resolver.sv
// cpu_operand_address_resolver: top level of the operand address resolver.
// Depends on oar_pkg, oar_ctrl and oar_dp.
//
//   channel   handshake        fields
//   -------   ---------------  ---------------------------------------------
//   input     start / busy     command mode operand index_value write_data
//   result    done             target effective_address port_select
//                              read_data forward_data error
//
// A word is taken when start is high and busy is low; busy stays high until
// the result has been shown. Immediate words go straight to the result, zero
// page and absolute words make one data access, the indirect modes first read
// the two pointer bytes: these and the data access share the single internal
// ram port, each read registered. The result is on the ports for the one cycle
// that done is high. Reset (rst, synchronous) returns the sequencer to idle;
// ram contents are not cleared. The receiver cannot stall.

module cpu_operand_address_resolver
  import oar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [2:0]  mode,
  input  logic [15:0] operand,
  input  logic [7:0]  index_value,
  input  logic [7:0]  write_data,
  output logic        done,
  output logic [2:0]  target,
  output logic [15:0] effective_address,
  output logic [2:0]  port_select,
  output logic [7:0]  read_data,
  output logic [7:0]  forward_data,
  output logic        error
);

  oar_cmd_t  cmd;
  oar_stat_t stat;

  // sequencer
  oar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath and ram
  oar_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .stat              (stat),
    .command           (command),
    .mode              (mode),
    .operand           (operand),
    .index_value       (index_value),
    .write_data        (write_data),
    .target            (target),
    .effective_address (effective_address),
    .port_select       (port_select),
    .read_data         (read_data),
    .forward_data      (forward_data),
    .error             (error)
  );

`ifndef NO_ASSERTIONS
  // an accepted word keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // a result is followed by a return to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block still busy after a result");

  // error only ever marks an immediate target
  a_error_imm: assert property (@(posedge clk) disable iff (rst)
    done && error |-> target == TGT_IMM)
    else $error("error flagged on a non-immediate target");

  // video results always land in the mirrored register window
  a_video_window: assert property (@(posedge clk) disable iff (rst)
    done && target == TGT_VIDEO |-> effective_address[15:3] == VID_BASE[15:3])
    else $error("video address outside register window");
`endif

endmodule
